>>> sv/msv_pkg.sv
`timescale 1ns / 1ps
package msv_pkg;

  localparam int AXES       = 3;
  localparam int COORD_BITS = 21;
  localparam int FRAC_BITS  = 15;

  localparam int VEC_W     = 63;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int XW        = COORD_BITS + 2;     // range compare width
  localparam int EW        = 64;                 // coherence error width
  localparam int PW        = 70;                 // |a| * t^2 product width
  localparam int T2_W      = 49;                 // t^2 in Q33.16
  localparam int T2_LO     = 25;
  localparam int T2_HI     = T2_W - T2_LO;
  localparam int SQI       = FRAC_BITS + 7;      // magnitude bits that get squared
  localparam int SQW       = 2 * SQI;

  localparam logic [63:0] ONE_Q      = 64'd1 << FRAC_BITS;
  localparam int          TOL_POS    = int'((ONE_Q + 64'd500) / 64'd1000);
  localparam int          TOL_LIM    = int'((ONE_Q * 64'd10 + 64'd500) / 64'd1000);
  localparam logic [63:0] TOL_COH    = ((ONE_Q << 16) + 64'd500) / 64'd1000;
  localparam logic [63:0] TOL_COH_SQ = TOL_COH * TOL_COH;

  typedef logic [3:0] err_code_t;
  localparam err_code_t ERR_OK       = 4'd0;
  localparam err_code_t ERR_START    = 4'd1;
  localparam err_code_t ERR_DURATION = 4'd2;
  localparam err_code_t ERR_POSITION = 4'd3;
  localparam err_code_t ERR_SPEED    = 4'd4;
  localparam err_code_t ERR_ACCEL    = 4'd5;
  localparam err_code_t ERR_VEL_COH  = 4'd6;
  localparam err_code_t ERR_POS_COH  = 4'd7;
  localparam err_code_t ERR_CONTINUE = 4'd8;
  localparam err_code_t ERR_ORIGIN   = 4'd9;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAX_DURATION = 3'd0;
  localparam cfg_idx_t CFG_BOX_MIN      = 3'd1;
  localparam cfg_idx_t CFG_BOX_MAX      = 3'd2;
  localparam cfg_idx_t CFG_SPEED_LIMIT  = 3'd3;
  localparam cfg_idx_t CFG_ACCEL_LIMIT  = 3'd4;
  localparam cfg_idx_t CFG_PATH_ORIGIN  = 3'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic           box_fail;
    logic           spd_fail;
    logic           acc_fail;
    logic           vel_big;
    logic [SQW-1:0] vel_sq;
    logic           pos_big;
    logic [SQW-1:0] pos_sq;
    logic           cont_fail;
    logic           org_diff;
  } lane_stat_t;

endpackage

>>> sv/msv_if.sv
`timescale 1ns / 1ps
interface msv_in_if;
  logic               valid;
  logic               ready;
  logic               first_of_path;
  logic signed [31:0] sect_start;
  logic [31:0]        duration;
  logic [62:0]        start_pos;
  logic [62:0]        end_pos;
  logic [62:0]        start_vel;
  logic [62:0]        end_vel;
  logic [62:0]        accel;

  modport source (output valid, first_of_path, sect_start, duration, start_pos, end_pos,
                  start_vel, end_vel, accel, input ready);
  modport sink (input valid, first_of_path, sect_start, duration, start_pos, end_pos,
                start_vel, end_vel, accel, output ready);
endinterface

interface msv_out_if;
  logic       valid;
  logic       ready;
  logic       section_ok;
  logic [3:0] error_code;
  logic       path_ok;

  modport source (output valid, section_ok, error_code, path_ok, input ready);
  modport sink (input valid, section_ok, error_code, path_ok, output ready);
endinterface

>>> sv/msv_lane.sv
`timescale 1ns / 1ps
module msv_lane (
  input  logic                      clk,
  input  msv_pkg::coord_t           p0,
  input  msv_pkg::coord_t           p1,
  input  msv_pkg::coord_t           v0,
  input  msv_pkg::coord_t           v1,
  input  msv_pkg::coord_t           acc,
  input  msv_pkg::coord_t           bmin,
  input  msv_pkg::coord_t           bmax,
  input  msv_pkg::coord_t           slim,
  input  msv_pkg::coord_t           alim,
  input  msv_pkg::coord_t           origin,
  input  msv_pkg::coord_t           prev_pos,
  input  msv_pkg::coord_t           prev_vel,
  input  logic [msv_pkg::TIME_W-1:0] dur,
  input  logic [msv_pkg::T2_W-1:0]   t2q,
  output msv_pkg::lane_stat_t       stat
);
  import msv_pkg::*;

  logic signed [XW-1:0] bx_lo, bx_hi, sp_lo, sp_hi, ac_lo, ac_hi;
  logic signed [COORD_BITS:0] dp, dv;
  logic box_f, spd_f, acc_f, cont_f, org_f;
  logic box_r, spd_r, acc_r, cont_r, org_r;

  logic signed [COORD_BITS+32:0] at_r, vt_r;
  logic [COORD_BITS-1:0]         m_r;
  logic                          aneg_r, aneg_d_r;
  logic signed [EW-1:0]          evel_r, epos_r;
  logic [COORD_BITS+T2_LO-1:0]   plo_r;
  logic [COORD_BITS+T2_HI-1:0]   phi_r;
  logic [PW-1:0]                 prod, prod_sat;
  logic signed [EW-1:0]          shalf;
  logic [EW-1:0]                 vmag, pmag;
  logic                          vbig_r, pbig_r;
  logic [SQW-1:0]                vsq_r, psq_r;

  always_comb begin
    bx_lo = XW'(bmin) - XW'(TOL_POS);
    bx_hi = XW'(bmax) + XW'(TOL_POS);
    sp_lo = -XW'(slim) - XW'(TOL_LIM);
    sp_hi = XW'(slim) + XW'(TOL_LIM);
    ac_lo = -XW'(alim) - XW'(TOL_LIM);
    ac_hi = XW'(alim) + XW'(TOL_LIM);
    box_f = (XW'(p0) < bx_lo) || (XW'(p0) > bx_hi) || (XW'(p1) < bx_lo) || (XW'(p1) > bx_hi);
    spd_f = (XW'(v0) < sp_lo) || (XW'(v0) > sp_hi) || (XW'(v1) < sp_lo) || (XW'(v1) > sp_hi);
    acc_f = (XW'(acc) < ac_lo) || (XW'(acc) > ac_hi);
    dp = (COORD_BITS+1)'(prev_pos) - (COORD_BITS+1)'(p0);
    dv = (COORD_BITS+1)'(prev_vel) - (COORD_BITS+1)'(v0);
    cont_f = (dp <= -(COORD_BITS+1)'(TOL_POS)) || (dp >= (COORD_BITS+1)'(TOL_POS)) ||
             (dv <= -(COORD_BITS+1)'(TOL_POS)) || (dv >= (COORD_BITS+1)'(TOL_POS));
    org_f = (p0 != origin);
  end

  // The quadratic term |a|*t^2 is split in two partial products and clamped at 2^61.
  always_comb begin
    prod = (PW'(phi_r) << T2_LO) + PW'(plo_r);
    prod_sat = (prod > (PW'(1) << 61)) ? (PW'(1) << 61) : prod;
    shalf = aneg_d_r ? -EW'(prod_sat[61:1]) : EW'(prod_sat[61:1]);
    vmag = evel_r[EW-1] ? EW'(-evel_r) : EW'(evel_r);
    pmag = epos_r[EW-1] ? EW'(-epos_r) : EW'(epos_r);
  end

  always_ff @(posedge clk) begin
    box_r  <= box_f;
    spd_r  <= spd_f;
    acc_r  <= acc_f;
    cont_r <= cont_f;
    org_r  <= org_f;
    at_r   <= acc * $signed({1'b0, dur});
    vt_r   <= v0 * $signed({1'b0, dur});
    m_r    <= acc[COORD_BITS-1] ? COORD_BITS'(-acc) : COORD_BITS'(acc);
    aneg_r <= acc[COORD_BITS-1];
    evel_r <= (EW'(v0) <<< 16) + EW'(at_r) - (EW'(v1) <<< 16);
    plo_r  <= m_r * t2q[T2_LO-1:0];
    phi_r  <= m_r * t2q[T2_W-1:T2_LO];
    aneg_d_r <= aneg_r;
    epos_r <= (EW'(p0) <<< 16) + EW'(vt_r) + shalf - (EW'(p1) <<< 16);
    vbig_r <= vmag >= TOL_COH;
    pbig_r <= pmag >= TOL_COH;
    vsq_r  <= vmag[SQI-1:0] * vmag[SQI-1:0];
    psq_r  <= pmag[SQI-1:0] * pmag[SQI-1:0];
  end

  always_comb begin
    stat.box_fail  = box_r;
    stat.spd_fail  = spd_r;
    stat.acc_fail  = acc_r;
    stat.vel_big   = vbig_r;
    stat.vel_sq    = vsq_r;
    stat.pos_big   = pbig_r;
    stat.pos_sq    = psq_r;
    stat.cont_fail = cont_r;
    stat.org_diff  = org_r;
  end

endmodule

>>> sv/msv_merge.sv
`timescale 1ns / 1ps
module msv_merge (
  input  msv_pkg::lane_stat_t lanes [msv_pkg::AXES],
  input  logic                start_neg,
  input  logic                dur_over,
  input  logic                from_origin,
  output msv_pkg::err_code_t  code
);
  import msv_pkg::*;

  logic [63:0] vsum, psum;
  logic box_f, spd_f, acc_f, vbig, pbig, cont_f, org_f;

  always_comb begin
    vsum = '0;
    psum = '0;
    box_f = 1'b0;
    spd_f = 1'b0;
    acc_f = 1'b0;
    vbig = 1'b0;
    pbig = 1'b0;
    cont_f = 1'b0;
    org_f = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      vsum = vsum + 64'(lanes[i].vel_sq);
      psum = psum + 64'(lanes[i].pos_sq);
      box_f = box_f | lanes[i].box_fail;
      spd_f = spd_f | lanes[i].spd_fail;
      acc_f = acc_f | lanes[i].acc_fail;
      vbig = vbig | lanes[i].vel_big;
      pbig = pbig | lanes[i].pos_big;
      cont_f = cont_f | lanes[i].cont_fail;
      org_f = org_f | lanes[i].org_diff;
    end
    if (start_neg) code = ERR_START;
    else if (dur_over) code = ERR_DURATION;
    else if (box_f) code = ERR_POSITION;
    else if (spd_f) code = ERR_SPEED;
    else if (acc_f) code = ERR_ACCEL;
    else if (vbig || vsum >= TOL_COH_SQ) code = ERR_VEL_COH;
    else if (pbig || psum >= TOL_COH_SQ) code = ERR_POS_COH;
    else if (from_origin) code = org_f ? ERR_ORIGIN : ERR_OK;
    else code = cont_f ? ERR_CONTINUE : ERR_OK;
  end

endmodule

>>> sv/motion_segment_validator.sv
`timescale 1ns / 1ps
// Checks one motion section per beat and returns one result beat per section. After a
// section is accepted, the per-axis lanes run a five-stage arithmetic pipeline (time
// products, velocity error, split quadratic-term products, position error, squares), then
// the merge stage picks the first failing check, the result is registered and the path
// state is updated. A new section is accepted in the cycle after the previous result is
// registered, while that result may still wait for its sink, so sections do not overlap; a
// result still waiting when the next one is done holds the pipeline until the sink takes
// it. Configuration registers take effect for sections accepted after the write, but the
// block does not enforce this: a write while a section is in flight can change its result.
module motion_segment_validator (
  input  logic                          clk,
  input  logic                          rst_n,
  msv_in_if.sink                        in_ch,
  msv_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [msv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msv_pkg::VEC_W-1:0]     cfg_data
);
  import msv_pkg::*;

  localparam logic [2:0] LAST = 3'd5;

  logic [TIME_W-1:0] max_dur_r;
  logic [VEC_W-1:0]  box_min_r, box_max_r, speed_lim_r, accel_lim_r, origin_r;
  logic [VEC_W-1:0]  prev_pos_r, prev_vel_r;
  logic              have_prev_r, path_good_r;

  logic              busy_r;
  logic [2:0]        cnt_r;
  logic              first_r, st_neg_r;
  logic [TIME_W-1:0] dur_r;
  logic [VEC_W-1:0]  p0_r, p1_r, v0_r, v1_r, a_r;
  logic [63:0]       tt_r;
  logic [T2_W-1:0]   t2q_r;

  logic              out_valid_r, sec_ok_r, path_ok_r;
  err_code_t         code_r, code;
  logic              finish, accept, ok, good_nxt;
  lane_stat_t        lanes [AXES];

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;
  assign finish = busy_r && (cnt_r == LAST) && (!out_valid_r || out_ch.ready);
  assign ok = (code == ERR_OK);
  assign good_nxt = first_r ? ok : (path_good_r && ok);

  assign out_ch.valid = out_valid_r;
  assign out_ch.section_ok = sec_ok_r;
  assign out_ch.error_code = code_r;
  assign out_ch.path_ok = path_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dur_r <= '0;
      box_min_r <= '0;
      box_max_r <= '0;
      speed_lim_r <= '0;
      accel_lim_r <= '0;
      origin_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DURATION: max_dur_r <= cfg_data[TIME_W-1:0];
        CFG_BOX_MIN:      box_min_r <= cfg_data;
        CFG_BOX_MAX:      box_max_r <= cfg_data;
        CFG_SPEED_LIMIT:  speed_lim_r <= cfg_data;
        CFG_ACCEL_LIMIT:  accel_lim_r <= cfg_data;
        CFG_PATH_ORIGIN:  origin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= in_ch.first_of_path;
      st_neg_r <= in_ch.sect_start[TIME_W-1];
      dur_r <= in_ch.duration;
      p0_r <= in_ch.start_pos;
      p1_r <= in_ch.end_pos;
      v0_r <= in_ch.start_vel;
      v1_r <= in_ch.end_vel;
      a_r <= in_ch.accel;
    end
    tt_r <= 64'(dur_r) * 64'(dur_r);
    t2q_r <= T2_W'(((tt_r >> 15) + 64'd1) >> 1);
    if (finish) begin
      sec_ok_r <= ok;
      code_r <= code;
      path_ok_r <= good_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      prev_pos_r <= '0;
      prev_vel_r <= '0;
      have_prev_r <= 1'b0;
      path_good_r <= 1'b1;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r && cnt_r != LAST) begin
        cnt_r <= cnt_r + 3'd1;
      end
      if (finish) begin
        busy_r <= 1'b0;
        out_valid_r <= 1'b1;
        prev_pos_r <= p1_r;
        prev_vel_r <= v1_r;
        have_prev_r <= 1'b1;
        path_good_r <= good_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    msv_lane u_lane (
      .clk      (clk),
      .p0       (p0_r[i*COORD_BITS +: COORD_BITS]),
      .p1       (p1_r[i*COORD_BITS +: COORD_BITS]),
      .v0       (v0_r[i*COORD_BITS +: COORD_BITS]),
      .v1       (v1_r[i*COORD_BITS +: COORD_BITS]),
      .acc      (a_r[i*COORD_BITS +: COORD_BITS]),
      .bmin     (box_min_r[i*COORD_BITS +: COORD_BITS]),
      .bmax     (box_max_r[i*COORD_BITS +: COORD_BITS]),
      .slim     (speed_lim_r[i*COORD_BITS +: COORD_BITS]),
      .alim     (accel_lim_r[i*COORD_BITS +: COORD_BITS]),
      .origin   (origin_r[i*COORD_BITS +: COORD_BITS]),
      .prev_pos (prev_pos_r[i*COORD_BITS +: COORD_BITS]),
      .prev_vel (prev_vel_r[i*COORD_BITS +: COORD_BITS]),
      .dur      (dur_r),
      .t2q      (t2q_r),
      .stat     (lanes[i])
    );
  end

  msv_merge u_merge (
    .lanes       (lanes),
    .start_neg   (st_neg_r),
    .dur_over    (dur_r > max_dur_r),
    .from_origin (first_r || !have_prev_r),
    .code        (code)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import msv_pkg::*;

  localparam longint Q_ONE    = 64'd1 << FRAC_BITS;
  localparam longint POS_TOL  = (Q_ONE + 500) / 1000;
  localparam longint LIM_TOL  = (Q_ONE * 10 + 500) / 1000;
  localparam longint unsigned COH_TOL = ((Q_ONE << 16) + 500) / 1000;
  localparam longint unsigned QUAD_SAT = 64'd1 << 61;
  localparam longint COORD_MAX = (64'd1 << (COORD_BITS - 1)) - 1;

  typedef struct {
    bit          first;
    logic [31:0] sect_start;
    logic [31:0] duration;
    logic [62:0] p0, p1, v0, v1, acc;
  } section_t;

  typedef struct {
    bit        ok;
    err_code_t code;
    bit        path;
  } verdict_t;

  typedef struct {
    logic [31:0] max_dur;
    logic [62:0] box_lo, box_hi, speed, accel, origin;
  } limits_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [VEC_W-1:0] cfg_data;

  msv_in_if  in_if();
  msv_out_if out_if();

  motion_segment_validator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the block: register copies and path state.
  limits_t     lim;
  logic [62:0] last_pos, last_vel;
  bit          seen_section;
  bit          path_good;

  // Generator state: where the last sent section ended.
  logic [62:0] walk_pos, walk_vel;
  longint      accel_amp;
  longint      dur_cap;

  verdict_t verdicts[$];
  int  fails;
  int  sections_sent;
  int  results_seen;
  int  settings_used;
  int  code_hits[16];
  bit  idle_on;
  int  holds_asked;
  int  holds_served;
  int  hold_left;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic longint axis(logic [62:0] v, int i);
    logic signed [COORD_BITS-1:0] c;
    c = v[i*COORD_BITS +: COORD_BITS];
    return longint'(c);
  endfunction

  function automatic logic [62:0] pack3(longint x, longint y, longint z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  function automatic bit inside_box(logic [62:0] p);
    for (int i = 0; i < AXES; i++)
      if (axis(p, i) < axis(lim.box_lo, i) - POS_TOL || axis(p, i) > axis(lim.box_hi, i) + POS_TOL)
        return 0;
    return 1;
  endfunction

  function automatic bit within_limit(logic [62:0] v, logic [62:0] bound);
    longint x, l;
    for (int i = 0; i < AXES; i++) begin
      x = axis(v, i);
      l = axis(bound, i);
      if (x < -l - LIM_TOL || x > l + LIM_TOL)
        return 0;
    end
    return 1;
  endfunction

  function automatic bit norm_small(longint e[3]);
    longint unsigned m, sum;
    sum = 0;
    for (int i = 0; i < AXES; i++) begin
      m = (e[i] < 0) ? longint'(-e[i]) : e[i];
      if (m >= COH_TOL)
        return 0;
      sum += m * m;
    end
    return sum < COH_TOL * COH_TOL;
  endfunction

  // Half of a*t^2 in Q.(FRAC+16), with t^2 rounded to Q33.16 and the product saturated.
  function automatic longint quad_half(longint a, longint t);
    longint unsigned tt, t2q, m, prod;
    longint h;
    tt = longint'(t) * longint'(t);
    t2q = ((tt >> 15) + 1) >> 1;
    m = (a < 0) ? longint'(-a) : a;
    if (m != 0 && t2q > QUAD_SAT / m) begin
      prod = QUAD_SAT;
    end else begin
      prod = m * t2q;
      if (prod > QUAD_SAT)
        prod = QUAD_SAT;
    end
    h = longint'(prod >> 1);
    return (a < 0) ? -h : h;
  endfunction

  function automatic bit near_vec(logic [62:0] x, logic [62:0] y);
    longint d;
    for (int i = 0; i < AXES; i++) begin
      d = axis(x, i) - axis(y, i);
      if (d <= -POS_TOL || d >= POS_TOL)
        return 0;
    end
    return 1;
  endfunction

  function automatic verdict_t judge_section(section_t s);
    verdict_t  r;
    longint    t;
    longint    ve[3], pe[3];
    bit        same;
    err_code_t code;
    t = s.duration;
    for (int i = 0; i < AXES; i++) begin
      ve[i] = axis(s.v0, i) * 65536 + axis(s.acc, i) * t - axis(s.v1, i) * 65536;
      pe[i] = axis(s.p0, i) * 65536 + axis(s.v0, i) * t + quad_half(axis(s.acc, i), t)
              - axis(s.p1, i) * 65536;
    end
    same = 1;
    for (int i = 0; i < AXES; i++)
      if (axis(s.p0, i) != axis(lim.origin, i))
        same = 0;
    code = ERR_OK;
    if (s.sect_start[31])
      code = ERR_START;
    else if (s.duration > lim.max_dur)
      code = ERR_DURATION;
    else if (!inside_box(s.p0) || !inside_box(s.p1))
      code = ERR_POSITION;
    else if (!within_limit(s.v0, lim.speed) || !within_limit(s.v1, lim.speed))
      code = ERR_SPEED;
    else if (!within_limit(s.acc, lim.accel))
      code = ERR_ACCEL;
    else if (!norm_small(ve))
      code = ERR_VEL_COH;
    else if (!norm_small(pe))
      code = ERR_POS_COH;
    else if (s.first || !seen_section) begin
      if (!same)
        code = ERR_ORIGIN;
    end else if (!near_vec(last_pos, s.p0) || !near_vec(last_vel, s.v0))
      code = ERR_CONTINUE;
    r.ok = (code == ERR_OK);
    r.code = code;
    path_good = s.first ? r.ok : (path_good && r.ok);
    r.path = path_good;
    last_pos = s.p1;
    last_vel = s.v1;
    seen_section = 1;
    return r;
  endfunction

  function automatic longint spread(longint amp);
    return longint'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  // A section obeying the motion equations, starting at the origin or near the walk's end.
  function automatic section_t lawful_section(bit first);
    section_t s;
    longint   t, p, v, a, v1[3], p1[3], pv[3], vv[3];
    s.first = first;
    s.sect_start = $urandom_range(0, 32'h7FFF_FFFF);
    t = $urandom_range(0, dur_cap);
    s.duration = t;
    for (int i = 0; i < AXES; i++) begin
      p = first ? axis(lim.origin, i) : axis(walk_pos, i);
      v = first ? spread(2 * Q_ONE) : axis(walk_vel, i);
      if (!first && $urandom_range(0, 7) == 0)
        p += spread(40);
      if (!first && $urandom_range(0, 7) == 0)
        v += spread(40);
      a = spread(accel_amp);
      if ((p > 8 * Q_ONE && a > 0) || (p < -8 * Q_ONE && a < 0) ||
          (v > 4 * Q_ONE && a > 0) || (v < -4 * Q_ONE && a < 0))
        a = -a;
      pv[i] = p;
      vv[i] = v;
      s.acc[i*COORD_BITS +: COORD_BITS] = a[20:0];
      v1[i] = (v * 65536 + a * t + 32768) >>> 16;
      p1[i] = (p * 65536 + v * t + quad_half(a, t) + 32768) >>> 16;
    end
    s.p0 = pack3(pv[0], pv[1], pv[2]);
    s.v0 = pack3(vv[0], vv[1], vv[2]);
    s.p1 = pack3(p1[0], p1[1], p1[2]);
    s.v1 = pack3(v1[0], v1[1], v1[2]);
    walk_pos = s.p1;
    walk_vel = s.v1;
    return s;
  endfunction

  function automatic section_t noise_section();
    section_t s;
    s.first = $urandom_range(0, 1);
    s.sect_start = $urandom;
    s.duration = $urandom;
    s.p0 = {$urandom, $urandom};
    s.p1 = {$urandom, $urandom};
    s.v0 = {$urandom, $urandom};
    s.v1 = {$urandom, $urandom};
    s.acc = {$urandom, $urandom};
    walk_pos = s.p1;
    walk_vel = s.v1;
    return s;
  endfunction

  // Receiver: checks each result beat and decides ready for the next cycle.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdicts.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        want = verdicts.pop_front();
        results_seen++;
        code_hits[want.code]++;
        if (out_if.section_ok !== want.ok) begin
          $error("section_ok: expected %0d, got %0d", want.ok, out_if.section_ok);
          fails++;
        end
        if (out_if.error_code !== want.code) begin
          $error("error_code: expected %0d, got %0d", want.code, out_if.error_code);
          fails++;
        end
        if (out_if.path_ok !== want.path) begin
          $error("path_ok: expected %0d, got %0d", want.path, out_if.path_ok);
          fails++;
        end
      end
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = 400;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Called at a rising edge; returns at the edge where the beat was taken, valid still high.
  task automatic send_section(section_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.first_of_path <= s.first;
    in_if.sect_start    <= s.sect_start;
    in_if.duration      <= s.duration;
    in_if.start_pos     <= s.p0;
    in_if.end_pos       <= s.p1;
    in_if.start_vel     <= s.v0;
    in_if.end_vel       <= s.v1;
    in_if.accel         <= s.acc;
    do @(posedge clk); while (!in_if.ready);
    verdicts.push_back(judge_section(s));
    sections_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [62:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_MAX_DURATION: lim.max_dur = val[31:0];
      CFG_BOX_MIN:      lim.box_lo = val;
      CFG_BOX_MAX:      lim.box_hi = val;
      CFG_SPEED_LIMIT:  lim.speed = val;
      CFG_ACCEL_LIMIT:  lim.accel = val;
      CFG_PATH_ORIGIN:  lim.origin = val;
      default: ;
    endcase
  endtask

  task automatic program_limits(limits_t c);
    put_reg(CFG_MAX_DURATION, {31'd0, c.max_dur});
    put_reg(CFG_BOX_MIN, c.box_lo);
    put_reg(CFG_BOX_MAX, c.box_hi);
    put_reg(CFG_SPEED_LIMIT, c.speed);
    put_reg(CFG_ACCEL_LIMIT, c.accel);
    put_reg(CFG_PATH_ORIGIN, c.origin);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic use_working_limits();
    limits_t c;
    c.max_dur = 32'h0002_0000;
    c.box_lo  = pack3(-16 * Q_ONE, -16 * Q_ONE, -16 * Q_ONE);
    c.box_hi  = pack3(16 * Q_ONE - 1, 16 * Q_ONE - 1, 16 * Q_ONE - 1);
    c.speed   = pack3(8 * Q_ONE, 8 * Q_ONE, 8 * Q_ONE);
    c.accel   = pack3(4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE);
    c.origin  = pack3(spread(4 * Q_ONE), spread(4 * Q_ONE), spread(4 * Q_ONE));
    program_limits(c);
    accel_amp = Q_ONE;
    dur_cap = Q_ONE;
  endtask

  task automatic use_widest_limits();
    limits_t c;
    c.max_dur = 32'hFFFF_FFFF;
    c.box_lo  = pack3(-COORD_MAX - 1, -COORD_MAX - 1, -COORD_MAX - 1);
    c.box_hi  = pack3(COORD_MAX, COORD_MAX, COORD_MAX);
    c.speed   = pack3(COORD_MAX, COORD_MAX, COORD_MAX);
    c.accel   = pack3(COORD_MAX, COORD_MAX, COORD_MAX);
    c.origin  = {63{1'b1}};
    program_limits(c);
    accel_amp = 4 * Q_ONE;
    dur_cap = 2 * Q_ONE;
  endtask

  // Tight or even negative limits: most sections fail early in the chain.
  task automatic use_random_limits();
    limits_t c;
    longint lo[3], hi[3];
    c.max_dur = $urandom_range(0, 32'h0001_0000);
    for (int i = 0; i < AXES; i++) begin
      lo[i] = spread(12 * Q_ONE);
      hi[i] = lo[i] + $urandom_range(0, 16 * Q_ONE);
    end
    c.box_lo = pack3(lo[0], lo[1], lo[2]);
    c.box_hi = pack3(hi[0], hi[1], hi[2]);
    c.speed  = pack3(spread(4 * Q_ONE), 4 * Q_ONE, $urandom_range(0, 4 * Q_ONE));
    c.accel  = pack3($urandom_range(0, 2 * Q_ONE), spread(2 * Q_ONE), 2 * Q_ONE);
    c.origin = pack3(spread(2 * Q_ONE), spread(2 * Q_ONE), spread(2 * Q_ONE));
    program_limits(c);
    accel_amp = Q_ONE;
    dur_cap = Q_ONE / 2;
  endtask

  task automatic test_reset_limits();
    section_t s;
    s = '{default: '0};
    send_section(s);                 // no previous section, so the origin rule applies
    s.p0 = pack3(10, 0, 0);
    s.p1 = s.p0;
    s.first = 1;
    send_section(s);                 // wrong origin, path goes bad
    s.first = 0;
    send_section(s);                 // passes but the path stays bad
    s.first = 1;
    s.p0 = '0;
    s.p1 = '0;
    s.duration = 1;                  // beyond a zero max_duration
    send_section(s);
    drain();
  endtask

  task automatic test_each_check();
    section_t base, s;
    use_working_limits();
    base = lawful_section(1);
    send_section(base);
    s = lawful_section(0);
    send_section(s);
    s = lawful_section(0);
    s.sect_start = 32'h8000_0000;
    send_section(s);
    s = lawful_section(0);
    s.duration = lim.max_dur + 1;
    send_section(s);
    s = lawful_section(0);
    s.duration = lim.max_dur;        // exactly at the limit
    send_section(s);
    s = lawful_section(1);
    s.p0[20:0] = axis(lim.box_hi, 0) + POS_TOL;       // on the margin, still inside
    s.p1[20:0] = axis(lim.box_hi, 0) + POS_TOL + 1;   // just outside
    send_section(s);
    s = lawful_section(1);
    s.p0[41:21] = axis(lim.box_lo, 1) - POS_TOL - 1;
    send_section(s);
    s = lawful_section(1);
    s.v0[62:42] = axis(lim.speed, 2) + LIM_TOL + 1;
    send_section(s);
    s = lawful_section(1);
    s.v1[20:0] = -axis(lim.speed, 0) - LIM_TOL - 1;
    send_section(s);
    s = lawful_section(1);
    s.acc[41:21] = axis(lim.accel, 1) + LIM_TOL + 1;
    send_section(s);
    s = lawful_section(1);
    s.v1[20:0] = s.v1[20:0] + 21'd40;
    send_section(s);
    s = lawful_section(1);
    s.p1[62:42] = s.p1[62:42] + 21'd40;
    send_section(s);
    s = lawful_section(1);
    s.p0[20:0] = s.p0[20:0] + 21'd1;
    s.p1[20:0] = s.p1[20:0] + 21'd1;  // coherent, but not at the origin
    send_section(s);
    base = lawful_section(1);
    send_section(base);
    walk_pos[20:0] = walk_pos[20:0] + 21'd40;
    s = lawful_section(0);            // position jumps past the continuity tolerance
    send_section(s);
    walk_vel[41:21] = walk_vel[41:21] - 21'd40;
    s = lawful_section(0);            // velocity jumps
    send_section(s);
    drain();
  endtask

  task automatic test_field_extremes();
    section_t s;
    use_widest_limits();
    s.first = 1;
    s.sect_start = 32'h7FFF_FFFF;
    s.duration = 32'hFFFF_FFFF;
    s.p0 = {63{1'b1}};
    s.p1 = {63{1'b1}};
    s.v0 = '0;
    s.v1 = '0;
    s.acc = pack3(COORD_MAX, -COORD_MAX - 1, 0);
    send_section(s);
    s.acc = '0;
    s.v0 = pack3(COORD_MAX, COORD_MAX, COORD_MAX);
    s.v1 = s.v0;
    send_section(s);
    s.v0 = pack3(-COORD_MAX - 1, 0, 0);
    s.v1 = s.v0;
    s.duration = 0;
    send_section(s);
    drain();
  endtask

  task automatic run_paths(int count);
    int left;
    section_t s;
    left = 0;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: s = noise_section();
        1: begin
          s = lawful_section(left == 0);
          case ($urandom_range(0, 3))
            0: s.p0[$urandom_range(0, 62)] ^= 1'b1;
            1: s.v1[$urandom_range(0, 62)] ^= 1'b1;
            2: s.acc[$urandom_range(0, 62)] ^= 1'b1;
            default: s.duration[$urandom_range(0, 31)] ^= 1'b1;
          endcase
        end
        default: begin
          if (left == 0)
            left = $urandom_range(2, 10);
          s = lawful_section(left == 0 || $urandom_range(0, 15) == 0);
        end
      endcase
      if (left > 0)
        left--;
      send_section(s);
    end
  endtask

  task automatic test_random_traffic();
    use_working_limits();
    run_paths(250);
    drain();
    use_widest_limits();
    run_paths(150);
    drain();
    repeat (4) begin
      use_random_limits();
      run_paths(25);
      drain();
    end
  endtask

  task automatic test_backpressure();
    use_working_limits();
    idle_on = 0;
    holds_asked++;
    run_paths(40);
    drain();                          // sender waits until every result is back
    idle_on = 1;
  endtask

  task automatic test_steady_stream();
    use_working_limits();
    idle_on = 0;
    run_paths(150);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_DURATION;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.first_of_path = 1'b0;
    in_if.sect_start = '0;
    in_if.duration = '0;
    in_if.start_pos = '0;
    in_if.end_pos = '0;
    in_if.start_vel = '0;
    in_if.end_vel = '0;
    in_if.accel = '0;
    lim = '{default: '0};
    last_pos = '0;
    last_vel = '0;
    seen_section = 0;
    path_good = 1;
    walk_pos = '0;
    walk_vel = '0;
    accel_amp = Q_ONE;
    dur_cap = 0;
    fails = 0;
    sections_sent = 0;
    results_seen = 0;
    settings_used = 1;
    holds_asked = 0;
    holds_served = 0;
    hold_left = 0;
    stall_left = 0;
    idle_on = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_limits();
    test_each_check();
    test_field_extremes();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();
    $display("%0d sections sent and %0d results checked under %0d register settings",
             sections_sent, results_seen, settings_used);
    $display("outcomes: ok %0d, start %0d, duration %0d, box %0d, speed %0d, accel %0d",
             code_hits[ERR_OK], code_hits[ERR_START], code_hits[ERR_DURATION],
             code_hits[ERR_POSITION], code_hits[ERR_SPEED], code_hits[ERR_ACCEL]);
    if (fails == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
